### hw/rtl/cbrns_pkg.sv
// shared constants and action codes for the cross-body radius neighbour search
package cbrns_pkg;

  localparam int DEF_MAX_BODIES  = 64;
  localparam int DEF_MAX_SAMPLES = 16;
  localparam int DEF_MAX_POINTS  = 256;

  localparam int COORD_W      = 16;
  localparam int DELTA_W      = 17;
  localparam int SQ_W         = 32;
  localparam int D2_W         = 34;
  localparam int RADIUS_W     = 36;
  localparam int ACTION_W     = 2;
  localparam int OUT_BODY_W   = 6;
  localparam int OUT_SAMPLE_W = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_FETCH = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

endpackage

### hw/rtl/cbrns_dist.sv
// squared distance unit: one squaring multiplier shared over the three axes
module cbrns_dist (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [cbrns_pkg::DELTA_W-1:0] dx,
  input  logic signed [cbrns_pkg::DELTA_W-1:0] dy,
  input  logic signed [cbrns_pkg::DELTA_W-1:0] dz,
  output logic                                done,
  output logic [cbrns_pkg::D2_W-1:0]          d2
);
  import cbrns_pkg::*;

  logic                       busy_r, busy_nxt;
  logic [1:0]                 step_r, step_nxt;
  logic                       done_r, done_nxt;
  logic [SQ_W-1:0]            prod_r, prod_nxt;
  logic [D2_W-1:0]            acc_r, acc_nxt;
  logic signed [DELTA_W-1:0]  op;
  logic signed [2*DELTA_W-1:0] sq;

  always_comb begin
    case (step_r)
      2'd0:    op = dx;
      2'd1:    op = dy;
      default: op = dz;
    endcase
  end

  assign sq = op * op;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      // square of one axis per step, added one step later
      prod_nxt = sq[SQ_W-1:0];
      if (step_r != 2'd0) begin
        acc_nxt = acc_r + {{(D2_W-SQ_W){1'b0}}, prod_r};
      end
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign done = done_r;
  assign d2   = acc_r;

endmodule

### hw/rtl/cross_body_radius_neighbor_search.sv
// Brute-force neighbour search over stored 3D samples grouped into bodies.
// Clear, load and ignored actions are handled in the idle state. A fetch
// walks candidate pairs of samples from different bodies in turn; each
// candidate takes a point read, the difference, then three passes
// through the shared squaring multiplier plus accumulate, reusing the
// body table read, which is done again when the pair of bodies changes.
// A fetch runs until the next hit or the end of the search, and the
// input is stalled meanwhile. The result sits in an output register, so
// the next item is taken while it waits. No clearing pass after reset is
// needed.
module cross_body_radius_neighbor_search #(
  parameter int MAX_BODIES           = cbrns_pkg::DEF_MAX_BODIES,
  parameter int MAX_SAMPLES_PER_BODY = cbrns_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_POINTS           = cbrns_pkg::DEF_MAX_POINTS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cbrns_pkg::RADIUS_W-1:0]        cfg_radius_squared,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [cbrns_pkg::ACTION_W-1:0]        in_action,
  input  logic                                  in_starts_body,
  input  logic signed [cbrns_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [cbrns_pkg::COORD_W-1:0]  in_pos_y,
  input  logic signed [cbrns_pkg::COORD_W-1:0]  in_pos_z,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_found,
  output logic [cbrns_pkg::OUT_BODY_W-1:0]      out_body_a,
  output logic [cbrns_pkg::OUT_SAMPLE_W-1:0]    out_sample_a,
  output logic [cbrns_pkg::OUT_BODY_W-1:0]      out_body_b,
  output logic [cbrns_pkg::OUT_SAMPLE_W-1:0]    out_sample_b,
  output logic signed [cbrns_pkg::DELTA_W-1:0]  out_delta_x,
  output logic signed [cbrns_pkg::DELTA_W-1:0]  out_delta_y,
  output logic signed [cbrns_pkg::DELTA_W-1:0]  out_delta_z,
  output logic                                  out_dropped_points
);
  import cbrns_pkg::*;

  localparam int BW   = $clog2(MAX_BODIES);
  localparam int BW1  = $clog2(MAX_BODIES + 1);
  localparam int SW   = $clog2(MAX_SAMPLES_PER_BODY + 1);
  localparam int PW   = $clog2(MAX_POINTS);
  localparam int PW1  = $clog2(MAX_POINTS + 1);
  localparam int SUMW = ((PW > SW) ? PW : SW) + 1;

  typedef struct packed {
    logic [PW-1:0] first;
    logic [SW-1:0] size;
  } body_ent_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDT  = 7'b0000010,
    S_TAB  = 7'b0000100,
    S_PT   = 7'b0001000,
    S_DIFF = 7'b0010000,
    S_DIST = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  // memories
  body_ent_t tab_mem [MAX_BODIES];
  point_t    pt_mem  [MAX_POINTS];
  body_ent_t tab_a_q, tab_b_q;
  point_t    pt_a_q, pt_b_q;

  // control state
  state_t         state_r, state_nxt;
  logic [RADIUS_W-1:0] radius_r;
  logic [BW1-1:0] body_total_r, body_total_nxt;
  logic [PW1-1:0] point_total_r, point_total_nxt;
  logic [BW-1:0]  last_body_r, last_body_nxt;
  logic [PW-1:0]  last_first_r, last_first_nxt;
  logic [SW-1:0]  last_size_r, last_size_nxt;
  logic           dropping_r, dropping_nxt;
  logic           ovf_r, ovf_nxt;
  logic [BW1-1:0] ca_r, ca_nxt, cb_r, cb_nxt;
  logic [SW-1:0]  sa_r, sa_nxt, sb_r, sb_nxt;
  logic           over_r, over_nxt;
  logic           out_valid_r, out_valid_nxt;

  // payload
  logic signed [DELTA_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic                      res_found_r, res_found_nxt;
  logic [BW1-1:0]            res_ba_r, res_ba_nxt, res_bb_r, res_bb_nxt;
  logic [SW-1:0]             res_sa_r, res_sa_nxt, res_sb_r, res_sb_nxt;
  logic signed [DELTA_W-1:0] res_dx_r, res_dx_nxt, res_dy_r, res_dy_nxt;
  logic signed [DELTA_W-1:0] res_dz_r, res_dz_nxt;
  logic                      o_found_r;
  logic [OUT_BODY_W-1:0]     o_ba_r, o_bb_r;
  logic [OUT_SAMPLE_W-1:0]   o_sa_r, o_sb_r;
  logic signed [DELTA_W-1:0] o_dx_r, o_dy_r, o_dz_r;
  logic                      o_drop_r;
  logic                      o_load;

  // memory ports
  logic            tab_we, tab_rd, pt_we, pt_rd;
  logic [BW-1:0]   tab_widx;
  body_ent_t       tab_wdata;
  logic [SUMW-1:0] pa_sum, pb_sum;
  logic [PW-1:0]   pa_addr, pb_addr;
  point_t          pt_wdata;

  // cursor advance
  logic [SW-1:0]  sb_inc, sa_inc;
  logic [BW1-1:0] cb_inc, ca_inc, ca_inc2;
  logic [BW1-1:0] adv_ca, adv_cb;
  logic [SW-1:0]  adv_sa, adv_sb;
  logic           adv_over, adv_body_chg;

  // distance unit
  logic            dist_start, dist_done;
  logic [D2_W-1:0] dist_d2;
  logic            hit;
  logic            starts;

  cbrns_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dist_start),
    .dx    (dx_r),
    .dy    (dy_r),
    .dz    (dz_r),
    .done  (dist_done),
    .d2    (dist_d2)
  );

  assign hit      = {{(RADIUS_W-D2_W){1'b0}}, dist_d2} < radius_r;
  assign starts   = in_starts_body || (body_total_r == '0);
  assign pa_sum   = SUMW'(tab_a_q.first) + SUMW'(sa_r);
  assign pb_sum   = SUMW'(tab_b_q.first) + SUMW'(sb_r);
  assign pa_addr  = pa_sum[PW-1:0];
  assign pb_addr  = pb_sum[PW-1:0];
  assign pt_wdata = '{x: in_pos_x, y: in_pos_y, z: in_pos_z};

  // next candidate after the current one
  always_comb begin
    sb_inc       = sb_r + SW'(1);
    sa_inc       = sa_r + SW'(1);
    cb_inc       = cb_r + BW1'(1);
    ca_inc       = ca_r + BW1'(1);
    ca_inc2      = ca_r + BW1'(2);
    adv_ca       = ca_r;
    adv_cb       = cb_r;
    adv_sa       = sa_r;
    adv_sb       = sb_r;
    adv_over     = 1'b0;
    adv_body_chg = 1'b0;
    if (sb_inc < tab_b_q.size) begin
      adv_sb = sb_inc;
    end else begin
      adv_sb = '0;
      if (sa_inc < tab_a_q.size) begin
        adv_sa = sa_inc;
      end else begin
        adv_sa       = '0;
        adv_body_chg = 1'b1;
        if (cb_inc < body_total_r) begin
          adv_cb = cb_inc;
        end else begin
          adv_ca   = ca_inc;
          adv_cb   = ca_inc2;
          adv_over = (ca_inc2 >= body_total_r);
        end
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    body_total_nxt  = body_total_r;
    point_total_nxt = point_total_r;
    last_body_nxt   = last_body_r;
    last_first_nxt  = last_first_r;
    last_size_nxt   = last_size_r;
    dropping_nxt    = dropping_r;
    ovf_nxt         = ovf_r;
    ca_nxt          = ca_r;
    cb_nxt          = cb_r;
    sa_nxt          = sa_r;
    sb_nxt          = sb_r;
    over_nxt        = over_r;
    dx_nxt          = dx_r;
    dy_nxt          = dy_r;
    dz_nxt          = dz_r;
    res_found_nxt   = res_found_r;
    res_ba_nxt      = res_ba_r;
    res_bb_nxt      = res_bb_r;
    res_sa_nxt      = res_sa_r;
    res_sb_nxt      = res_sb_r;
    res_dx_nxt      = res_dx_r;
    res_dy_nxt      = res_dy_r;
    res_dz_nxt      = res_dz_r;
    tab_we          = 1'b0;
    tab_rd          = 1'b0;
    tab_widx        = last_body_r;
    tab_wdata       = '{first: last_first_r, size: last_size_r};
    pt_we           = 1'b0;
    pt_rd           = 1'b0;
    dist_start      = 1'b0;
    o_load          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_CLEAR: begin
              body_total_nxt  = '0;
              point_total_nxt = '0;
              ovf_nxt         = 1'b0;
              dropping_nxt    = 1'b0;
              ca_nxt          = '0;
              cb_nxt          = BW1'(1);
              sa_nxt          = '0;
              sb_nxt          = '0;
              over_nxt        = 1'b0;
            end
            ACT_LOAD: begin
              if (starts) begin
                if (body_total_r >= BW1'(MAX_BODIES) ||
                    point_total_r >= PW1'(MAX_POINTS)) begin
                  ovf_nxt      = 1'b1;
                  dropping_nxt = 1'b1;
                end else begin
                  dropping_nxt    = 1'b0;
                  tab_we          = 1'b1;
                  tab_widx        = body_total_r[BW-1:0];
                  tab_wdata       = '{first: point_total_r[PW-1:0], size: SW'(1)};
                  last_body_nxt   = body_total_r[BW-1:0];
                  last_first_nxt  = point_total_r[PW-1:0];
                  last_size_nxt   = SW'(1);
                  body_total_nxt  = body_total_r + BW1'(1);
                  pt_we           = 1'b1;
                  point_total_nxt = point_total_r + PW1'(1);
                  ca_nxt          = '0;
                  cb_nxt          = BW1'(1);
                  sa_nxt          = '0;
                  sb_nxt          = '0;
                  over_nxt        = 1'b0;
                end
              end else if (dropping_r || point_total_r >= PW1'(MAX_POINTS) ||
                           last_size_r >= SW'(MAX_SAMPLES_PER_BODY)) begin
                ovf_nxt = 1'b1;
              end else begin
                // grow the open body
                tab_we          = 1'b1;
                tab_widx        = last_body_r;
                tab_wdata       = '{first: last_first_r, size: last_size_r + SW'(1)};
                last_size_nxt   = last_size_r + SW'(1);
                pt_we           = 1'b1;
                point_total_nxt = point_total_r + PW1'(1);
                ca_nxt          = '0;
                cb_nxt          = BW1'(1);
                sa_nxt          = '0;
                sb_nxt          = '0;
                over_nxt        = 1'b0;
              end
            end
            ACT_FETCH: begin
              if (body_total_r < BW1'(2) || over_r) begin
                over_nxt      = 1'b1;
                res_found_nxt = 1'b0;
                res_ba_nxt    = '0;
                res_bb_nxt    = '0;
                res_sa_nxt    = '0;
                res_sb_nxt    = '0;
                res_dx_nxt    = '0;
                res_dy_nxt    = '0;
                res_dz_nxt    = '0;
                state_nxt     = S_OUT;
              end else begin
                tab_rd    = 1'b1;
                state_nxt = S_TAB;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RDT: begin
        tab_rd    = 1'b1;
        state_nxt = S_TAB;
      end
      S_TAB: begin
        pt_rd     = 1'b1;
        state_nxt = S_PT;
      end
      S_PT: begin
        dx_nxt    = DELTA_W'(pt_a_q.x) - DELTA_W'(pt_b_q.x);
        dy_nxt    = DELTA_W'(pt_a_q.y) - DELTA_W'(pt_b_q.y);
        dz_nxt    = DELTA_W'(pt_a_q.z) - DELTA_W'(pt_b_q.z);
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        dist_start = 1'b1;
        state_nxt  = S_DIST;
      end
      S_DIST: begin
        if (dist_done) begin
          ca_nxt   = adv_ca;
          cb_nxt   = adv_cb;
          sa_nxt   = adv_sa;
          sb_nxt   = adv_sb;
          over_nxt = adv_over;
          if (hit) begin
            res_found_nxt = 1'b1;
            res_ba_nxt    = ca_r;
            res_bb_nxt    = cb_r;
            res_sa_nxt    = sa_r;
            res_sb_nxt    = sb_r;
            res_dx_nxt    = dx_r;
            res_dy_nxt    = dy_r;
            res_dz_nxt    = dz_r;
            state_nxt     = S_OUT;
          end else if (adv_over) begin
            res_found_nxt = 1'b0;
            res_ba_nxt    = '0;
            res_bb_nxt    = '0;
            res_sa_nxt    = '0;
            res_sb_nxt    = '0;
            res_dx_nxt    = '0;
            res_dy_nxt    = '0;
            res_dz_nxt    = '0;
            state_nxt     = S_OUT;
          end else if (adv_body_chg) begin
            state_nxt = S_RDT;
          end else begin
            state_nxt = S_TAB;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          o_load    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (o_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      radius_r      <= '0;
      body_total_r  <= '0;
      point_total_r <= '0;
      last_body_r   <= '0;
      last_first_r  <= '0;
      last_size_r   <= '0;
      dropping_r    <= 1'b0;
      ovf_r         <= 1'b0;
      ca_r          <= '0;
      cb_r          <= BW1'(1);
      sa_r          <= '0;
      sb_r          <= '0;
      over_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_valid) begin
        radius_r <= cfg_radius_squared;
      end
      body_total_r  <= body_total_nxt;
      point_total_r <= point_total_nxt;
      last_body_r   <= last_body_nxt;
      last_first_r  <= last_first_nxt;
      last_size_r   <= last_size_nxt;
      dropping_r    <= dropping_nxt;
      ovf_r         <= ovf_nxt;
      ca_r          <= ca_nxt;
      cb_r          <= cb_nxt;
      sa_r          <= sa_nxt;
      sb_r          <= sb_nxt;
      over_r        <= over_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    dz_r        <= dz_nxt;
    res_found_r <= res_found_nxt;
    res_ba_r    <= res_ba_nxt;
    res_bb_r    <= res_bb_nxt;
    res_sa_r    <= res_sa_nxt;
    res_sb_r    <= res_sb_nxt;
    res_dx_r    <= res_dx_nxt;
    res_dy_r    <= res_dy_nxt;
    res_dz_r    <= res_dz_nxt;
    if (o_load) begin
      o_found_r <= res_found_r;
      o_ba_r    <= OUT_BODY_W'(res_ba_r);
      o_bb_r    <= OUT_BODY_W'(res_bb_r);
      o_sa_r    <= OUT_SAMPLE_W'(res_sa_r);
      o_sb_r    <= OUT_SAMPLE_W'(res_sb_r);
      o_dx_r    <= res_dx_r;
      o_dy_r    <= res_dy_r;
      o_dz_r    <= res_dz_r;
      o_drop_r  <= ovf_r;
    end
  end

  // body table: one write, two registered reads
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_widx] <= tab_wdata;
    end
    if (tab_rd) begin
      tab_a_q <= tab_mem[ca_r[BW-1:0]];
      tab_b_q <= tab_mem[cb_r[BW-1:0]];
    end
  end

  // point store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[point_total_r[PW-1:0]] <= pt_wdata;
    end
    if (pt_rd) begin
      pt_a_q <= pt_mem[pa_addr];
      pt_b_q <= pt_mem[pb_addr];
    end
  end

  assign cfg_ready          = 1'b1;
  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_found          = o_found_r;
  assign out_body_a         = o_ba_r;
  assign out_sample_a       = o_sa_r;
  assign out_body_b         = o_bb_r;
  assign out_sample_b       = o_sb_r;
  assign out_delta_x        = o_dx_r;
  assign out_delta_y        = o_dy_r;
  assign out_delta_z        = o_dz_r;
  assign out_dropped_points = o_drop_r;

endmodule
